// ----- rtl/hilp_pkg.sv -----
// Package for the linear-probing hash table block.
// Holds the field widths, command and status codes and the register map.
// No dependencies.
`default_nettype none

package hilp_pkg;

  localparam int CMD_W      = 1;
  localparam int KEY_W      = 30;
  localparam int PAYLOAD_W  = 16;
  localparam int SLOT_W     = 10;
  localparam int STATUS_W   = 2;
  localparam int SIZE_W     = 11;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(631);

  localparam logic [CMD_W-1:0] CMD_INSERT = 1'b0;
  localparam logic [CMD_W-1:0] CMD_READ   = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_READ     = 2'd2;

  localparam logic REG_TABLE_SIZE = 1'b0;

endpackage

`default_nettype wire

// ----- rtl/hilp_if.sv -----
// Valid/ready channel interfaces for the hash table: command items in, result items out.
// Depends on hilp_pkg.
`default_nettype none

interface hilp_in_if;
  import hilp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     command;
  logic [KEY_W-1:0]     key;
  logic [PAYLOAD_W-1:0] payload;
  logic [SLOT_W-1:0]    read_slot;

  modport source(output valid, command, key, payload, read_slot, input ready);
  modport sink(input valid, command, key, payload, read_slot, output ready);
endinterface

interface hilp_out_if;
  import hilp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [SLOT_W-1:0]    slot;
  logic                 occupied;
  logic [KEY_W-1:0]     key_out;
  logic [PAYLOAD_W-1:0] payload_out;

  modport source(output valid, status, slot, occupied, key_out, payload_out, input ready);
  modport sink(input valid, status, slot, occupied, key_out, payload_out, output ready);
endinterface

`default_nettype wire

// ----- rtl/hilp_mod.sv -----
// Iterative remainder unit: one restoring step per cycle, one dividend bit at a time.
// Produces dividend mod divisor; done pulses for one cycle with the remainder valid.
// No dependencies.
`default_nettype none

module hilp_mod #(
  parameter int DIVIDEND_W = 30,
  parameter int DIVISOR_W  = 11
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [DIVISOR_W-1:0]  divisor,
  output logic                       done,
  output logic [DIVISOR_W-1:0]       rem
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [DIVIDEND_W-1:0] dvd_r, dvd_nxt;
  logic [DIVISOR_W-1:0]  dvs_r, dvs_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVISOR_W:0]    trial;

  assign trial = {rem_r, dvd_r[DIVIDEND_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DIVIDEND_W);
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[DIVIDEND_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = DIVISOR_W'(trial - {1'b0, dvs_r});
      end else begin
        rem_nxt = DIVISOR_W'(trial);
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

// ----- rtl/hash_insert_linear_probe.sv -----
// Open-addressing hash table with a division-method home slot and linear probing.
// An insert gets its home slot from the bit-serial remainder unit, then probes slot by slot:
// each probe reads the registered slot memory and checks the entry; S_FINISH hands off the result.
// A read of a slot within the depth does one slot memory read and one check. The next item is
// accepted in the cycle after the result is loaded, unless a waiting result holds it.
// Reset sweeps every slot of the memory. Depends on hilp_pkg, hilp_if, hilp_mod.
`default_nettype none

module hash_insert_linear_probe #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  hilp_in_if.sink                              in_ch,
  hilp_out_if.source                           out_ch,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [hilp_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [hilp_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [hilp_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                                 cfg_pready
);

  import hilp_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int RW = $clog2(TABLE_DEPTH + 1);

  typedef struct packed {
    logic                 occupied;
    logic [KEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0] payload;
  } entry_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [SLOT_W-1:0]    slot;
    logic                 occupied;
    logic [KEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0] payload;
  } res_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_PROBE_RD,
    S_PROBE_CHK,
    S_READ_RD,
    S_READ_CHK,
    S_FINISH
  } state_t;

  state_t               state_r, state_nxt;
  logic [AW-1:0]        clr_addr_r, clr_addr_nxt;
  logic [AW-1:0]        pos_r, pos_nxt;
  logic [RW-1:0]        cnt_r, cnt_nxt;
  logic [KEY_W-1:0]     key_r, key_nxt;
  logic [PAYLOAD_W-1:0] payload_r, payload_nxt;
  logic [SLOT_W-1:0]    rslot_r, rslot_nxt;
  res_t                 res_r, res_nxt;
  logic                 out_valid_r, out_valid_nxt;
  res_t                 out_res_r, out_res_nxt;
  logic [SIZE_W-1:0]    table_size_r;

  entry_t               mem [TABLE_DEPTH];
  entry_t               rd_data_r;
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  entry_t               mem_wdata;

  logic [RW-1:0]        size_u;
  logic [RW-1:0]        pos_p1;
  logic [RW-1:0]        cnt_p1;
  logic                 in_accept;
  logic                 rslot_oob;
  logic                 mod_start, mod_done;
  logic [RW-1:0]        mod_rem;
  logic                 cfg_wr;

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_TABLE_SIZE) begin
      cfg_prdata = CFG_DATA_W'(table_size_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= SIZE_RESET;
    end else if (cfg_wr && cfg_paddr[2] == REG_TABLE_SIZE) begin
      table_size_r <= cfg_pwdata[SIZE_W-1:0];
    end
  end

  // Size in use is clamped to the range one to the memory depth.
  always_comb begin
    if (table_size_r == '0) begin
      size_u = RW'(1);
    end else if (32'(table_size_r) > 32'(TABLE_DEPTH)) begin
      size_u = RW'(TABLE_DEPTH);
    end else begin
      size_u = RW'(table_size_r);
    end
  end

  assign in_accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign rslot_oob = (32'(in_ch.read_slot) >= 32'(TABLE_DEPTH));
  assign pos_p1 = RW'(pos_r) + RW'(1);
  assign cnt_p1 = cnt_r + RW'(1);
  assign mod_start = in_accept && (in_ch.command == CMD_INSERT);

  hilp_mod #(
    .DIVIDEND_W(KEY_W),
    .DIVISOR_W (RW)
  ) u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mod_start),
    .dividend(in_ch.key),
    .divisor (size_u),
    .done    (mod_done),
    .rem     (mod_rem)
  );

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    key_nxt       = key_r;
    payload_nxt   = payload_r;
    rslot_nxt     = rslot_r;
    res_nxt       = res_r;
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r;
    mem_we        = 1'b0;
    mem_waddr     = pos_r;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = pos_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(TABLE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          key_nxt     = in_ch.key;
          payload_nxt = in_ch.payload;
          rslot_nxt   = in_ch.read_slot;
          if (in_ch.command == CMD_INSERT) begin
            state_nxt = S_DIV;
          end else if (rslot_oob) begin
            res_nxt   = '{status: ST_READ, slot: in_ch.read_slot, default: '0};
            state_nxt = S_FINISH;
          end else begin
            state_nxt = S_READ_RD;
          end
        end
      end
      S_DIV: begin
        if (mod_done) begin
          pos_nxt   = AW'(mod_rem);
          cnt_nxt   = '0;
          state_nxt = S_PROBE_RD;
        end
      end
      S_PROBE_RD: begin
        mem_re    = 1'b1;
        state_nxt = S_PROBE_CHK;
      end
      S_PROBE_CHK: begin
        if (!rd_data_r.occupied) begin
          mem_we    = 1'b1;
          mem_wdata = '{occupied: 1'b1, key: key_r, payload: payload_r};
          res_nxt   = '{status: ST_INSERTED, slot: SLOT_W'(pos_r), occupied: 1'b1,
                        key: key_r, payload: payload_r};
          state_nxt = S_FINISH;
        end else if (cnt_p1 == size_u) begin
          res_nxt   = '{status: ST_FULL, default: '0};
          state_nxt = S_FINISH;
        end else begin
          cnt_nxt   = cnt_p1;
          pos_nxt   = (pos_p1 >= size_u) ? '0 : AW'(pos_p1);
          state_nxt = S_PROBE_RD;
        end
      end
      S_READ_RD: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(rslot_r);
        state_nxt = S_READ_CHK;
      end
      S_READ_CHK: begin
        if (rd_data_r.occupied) begin
          res_nxt = '{status: ST_READ, slot: rslot_r, occupied: 1'b1,
                      key: rd_data_r.key, payload: rd_data_r.payload};
        end else begin
          res_nxt = '{status: ST_READ, slot: rslot_r, default: '0};
        end
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_res_nxt   = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
    pos_r     <= pos_nxt;
    key_r     <= key_nxt;
    payload_r <= payload_nxt;
    rslot_r   <= rslot_nxt;
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
  end

  // Slot memory. Reads and writes never target the same cycle, so no forwarding is needed.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_res_r.status;
  assign out_ch.slot        = out_res_r.slot;
  assign out_ch.occupied    = out_res_r.occupied;
  assign out_ch.key_out     = out_res_r.key;
  assign out_ch.payload_out = out_res_r.payload;

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_ch.ready)
    else $error("Item accepted during the clearing sweep.");

  a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE_RD) |-> (RW'(pos_r) < size_u))
    else $error("Probe address beyond the table size in use.");

  a_probe_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE_CHK) |-> (cnt_r < size_u))
    else $error("Probe count exceeded the table size in use.");

  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_CLEAR || state_r == S_PROBE_CHK))
    else $error("Slot memory written outside clearing or insert.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r != S_IDLE))
    else $error("Block idle right after accepting an item.");

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for hash_insert_linear_probe: drives insert and slot-read items
// over several table sizes and compares every result with an in-bench model of the table.
// Depends on hilp_pkg, hilp_if and the hash_insert_linear_probe RTL.

module testbench;
  import hilp_pkg::*;

  localparam int SLOTS = 1024;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 40;
  localparam logic [CFG_ADDR_W-1:0] SIZE_ADDR = CFG_ADDR_W'(4 * REG_TABLE_SIZE);

  typedef struct {
    logic [CMD_W-1:0]     cmd;
    logic [KEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0] payload;
    logic [SLOT_W-1:0]    rslot;
  } probe_cmd_t;

  typedef struct {
    logic [STATUS_W-1:0]  status;
    logic [SLOT_W-1:0]    slot;
    logic                 occupied;
    logic [KEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0] payload;
  } slot_report_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  hilp_in_if  in_ch();
  hilp_out_if out_ch();

  hash_insert_linear_probe #(.TABLE_DEPTH(SLOTS)) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mirror of the table contents and the size register.
  bit                   slot_used [SLOTS];
  bit [KEY_W-1:0]       slot_key [SLOTS];
  bit [PAYLOAD_W-1:0]   slot_payload [SLOTS];
  logic [SIZE_W-1:0]    size_reg;
  int unsigned          written_slots[$];

  probe_cmd_t   commands_waiting[$];
  slot_report_t slot_reports_due[$];

  int unsigned tx_idle;
  int unsigned rx_idle;
  int unsigned errors;
  int unsigned placed_cnt;
  int unsigned full_cnt;
  int unsigned read_cnt;
  int unsigned quiet;
  int unsigned size_a;
  int unsigned size_b;

  function automatic slot_report_t place_or_fetch(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] k,
                                                  logic [PAYLOAD_W-1:0] p,
                                                  logic [SLOT_W-1:0] rs);
    slot_report_t r;
    int unsigned span;
    int unsigned pos;
    int unsigned n;
    r = '{status: ST_FULL, slot: '0, occupied: 1'b0, key: '0, payload: '0};
    if (cmd == CMD_READ) begin
      read_cnt++;
      r.status = ST_READ;
      r.slot = rs;
      if (slot_used[rs]) begin
        r.occupied = 1'b1;
        r.key = slot_key[rs];
        r.payload = slot_payload[rs];
      end
      return r;
    end
    span = (size_reg == 0) ? 1 : (size_reg > SLOTS) ? SLOTS : size_reg;
    pos = k % span;
    for (n = 0; n < span; n++) begin
      if (!slot_used[pos]) begin
        slot_used[pos] = 1'b1;
        slot_key[pos] = k;
        slot_payload[pos] = p;
        written_slots.push_back(pos);
        placed_cnt++;
        r = '{status: ST_INSERTED, slot: SLOT_W'(pos), occupied: 1'b1, key: k, payload: p};
        return r;
      end
      pos = (pos + 1 >= span) ? 0 : pos + 1;
    end
    full_cnt++;
    return r;
  endfunction

  always @(posedge clk) begin
    probe_cmd_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        slot_reports_due.push_back(place_or_fetch(in_ch.command, in_ch.key, in_ch.payload,
                                                  in_ch.read_slot));
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (commands_waiting.size() != 0 && $urandom_range(99) >= tx_idle) begin
          nxt = commands_waiting.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.command   <= nxt.cmd;
          in_ch.key       <= nxt.key;
          in_ch.payload   <= nxt.payload;
          in_ch.read_slot <= nxt.rslot;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string what, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    slot_report_t got;
    slot_report_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{status: out_ch.status, slot: out_ch.slot, occupied: out_ch.occupied,
                key: out_ch.key_out, payload: out_ch.payload_out};
        if (slot_reports_due.size() == 0) begin
          $display("%0t: unexpected result: expected none, got status %0d slot %0d", $time,
                   got.status, got.slot);
          errors++;
        end else begin
          want = slot_reports_due.pop_front();
          check_field("status", want.status, got.status);
          check_field("slot", want.slot, got.slot);
          check_field("occupied", want.occupied, got.occupied);
          check_field("key_out", want.key, got.key);
          check_field("payload_out", want.payload, got.payload);
        end
      end
      out_ch.ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_psel)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic feed(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] k, logic [PAYLOAD_W-1:0] p,
                      logic [SLOT_W-1:0] rs);
    while (commands_waiting.size() >= 2)
      @(negedge clk);
    commands_waiting.push_back('{cmd: cmd, key: k, payload: p, rslot: rs});
  endtask

  task automatic drain();
    do
      @(negedge clk);
    while (commands_waiting.size() != 0 || in_ch.valid || slot_reports_due.size() != 0);
  endtask

  task automatic set_table_size(int unsigned value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= SIZE_ADDR;
    cfg_pwdata  <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do
      @(posedge clk);
    while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    size_reg = SIZE_W'(value);
  endtask

  task automatic random_batch(int unsigned count, int unsigned span);
    int unsigned dice;
    int unsigned idx;
    logic [KEY_W-1:0] k;
    repeat (count) begin
      dice = $urandom_range(99);
      if (dice < 40 && written_slots.size() != 0) begin
        idx = (dice < 10) ? written_slots.size() - 1 : $urandom_range(written_slots.size() - 1);
        feed(CMD_READ, KEY_W'($urandom_range(999999999)), PAYLOAD_W'($urandom_range(16'hFFFF)),
             SLOT_W'(written_slots[idx]));
      end else begin
        // Most keys land on a few neighboring home slots so that clusters build up.
        if (dice < 75)
          k = KEY_W'($urandom_range(999999999 / span - 1) * span
                     + $urandom_range(((span < 8) ? span : 8) - 1));
        else
          k = KEY_W'($urandom_range(999999999));
        feed(CMD_INSERT, k, PAYLOAD_W'($urandom_range(16'hFFFF)),
             SLOT_W'($urandom_range(SLOTS - 1)));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_INSERT;
    in_ch.key = '0;
    in_ch.payload = '0;
    in_ch.read_slot = '0;
    out_ch.ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    size_reg = SIZE_RESET;
    errors = 0;
    placed_cnt = 0;
    full_cnt = 0;
    read_cnt = 0;
    quiet = 0;
    tx_idle = 6;
    rx_idle = 81;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // At the reset size: collisions, a duplicate key and a probe that wraps to slot 0.
    feed(CMD_INSERT, 30'd0, 16'h0000, 10'd0);
    feed(CMD_INSERT, 30'd999999999, 16'hFFFF, 10'd1023);
    feed(CMD_INSERT, 30'd631, 16'h1234, 10'd0);
    feed(CMD_INSERT, 30'd0, 16'h0005, 10'd0);
    feed(CMD_INSERT, 30'd630, 16'hA5A5, 10'd0);
    feed(CMD_INSERT, 30'd3785, 16'h5A5A, 10'd0);
    feed(CMD_READ, 30'd0, 16'h0000, 10'd0);
    feed(CMD_READ, 30'h3FFFFFFF, 16'hFFFF, 10'd630);
    feed(CMD_READ, 30'd0, 16'h0000, 10'd3);
    feed(CMD_READ, 30'd0, 16'h0000, 10'd33);
    drain();

    // A size of zero acts as one slot, already taken, so the table is full.
    set_table_size(0);
    feed(CMD_INSERT, 30'd12345, 16'h0101, 10'd0);
    feed(CMD_READ, 30'd0, 16'h0000, 10'd1);
    drain();
    set_table_size(1);
    feed(CMD_INSERT, 30'd999999999, 16'hFFFF, 10'd0);
    drain();

    // A size above the depth is clipped to the depth.
    set_table_size(2047);
    feed(CMD_INSERT, 30'd1023, 16'h0F0F, 10'd0);
    feed(CMD_INSERT, 30'd2047, 16'hF0F0, 10'd0);
    feed(CMD_READ, 30'd0, 16'h0000, 10'd1023);
    feed(CMD_READ, 30'd0, 16'h0000, 10'd4);
    drain();

    size_a = $urandom_range(64, 128);
    set_table_size(size_a);
    random_batch(380, size_a);
    drain();

    tx_idle = 81;
    rx_idle = 6;
    size_b = $urandom_range(300, 520);
    set_table_size(size_b);
    random_batch(380, size_b);
    drain();

    tx_idle = 0;
    rx_idle = 0;
    set_table_size(SLOTS);
    random_batch(180, SLOTS);
    drain();
    random_batch(180, SLOTS);
    drain();

    // Shrunk table: inserts find it full, while entries above the size stay readable.
    set_table_size(3);
    random_batch(20, 3);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Checked %0d placed inserts, %0d table-full inserts and %0d slot reads,", placed_cnt,
             full_cnt, read_cnt);
    $display("with table sizes 631, 0, 1, 2047, %0d, %0d, %0d and 3.", size_a, size_b, SLOTS);
    if (errors == 0 && slot_reports_due.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
